// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i, reset rst_ni.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define WVN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent implies consequent on the next edge
`define WVN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/wvn_pkg.sv
// ---------------------------------------------------------------------------
// wvn_pkg
// Types and constants of the weighted vector normalizer.
// ---------------------------------------------------------------------------
`default_nettype none
package wvn_pkg;
  localparam int MaxPoints = 64;
  localparam int AddrW     = $clog2(MaxPoints);
  localparam int CntW      = $clog2(MaxPoints + 1);
  localparam int GridW     = 7;
  localparam int ShiftW    = 6;
  localparam int CfgDataW  = 7;
  localparam int TotalW    = 58;
  localparam int ProdW     = 63;
  localparam int PtW       = 47;
  localparam int RemW      = TotalW + 1;
  localparam logic [TotalW-1:0] TotalMax = '1;

  typedef enum logic [0:0] {
    CFG_GRID_POINTS = 1'b0,
    CFG_TOL_SHIFT   = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_COUNT     = 3'd1,
    ST_BAD_WT    = 3'd2,
    ST_TOO_NEG   = 3'd3,
    ST_NO_POS    = 3'd4,
    ST_ZERO_SUM  = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_LOAD, S_EVAL, S_CRD, S_CMUL, S_CACC, S_DRD, S_DMUL, S_DST, S_DDIV, S_OUT
  } state_e;

  typedef struct packed {
    logic         start;
    logic [PtW-1:0]    num;
    logic [TotalW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } div_rsp_t;
endpackage
`default_nettype wire

// File: rtl/core/wvn_if.sv
// ---------------------------------------------------------------------------
// wvn_in_if / wvn_out_if
// Valid-ready channels for sample beats and result beats.
// ---------------------------------------------------------------------------
`default_nettype none
interface wvn_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] density_value;
  logic        [31:0] quad_weight;
  logic               last_in;
  modport source (output valid, density_value, quad_weight, last_in, input ready);
  modport sink   (input valid, density_value, quad_weight, last_in, output ready);
endinterface

interface wvn_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] norm_weight;
  logic [2:0]  status;
  logic        last_out;
  modport source (output valid, norm_weight, status, last_out, input ready);
  modport sink   (input valid, norm_weight, status, last_out, output ready);
endinterface
`default_nettype wire

// File: rtl/core/wvn_store.sv
// ---------------------------------------------------------------------------
// wvn_store
// Sample memory, one write and one registered read port, {value, weight}.
// ---------------------------------------------------------------------------
`default_nettype none
module wvn_store
  import wvn_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [63:0]      wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [63:0]      rdata_o
);
  logic [63:0] mem_q [MaxPoints];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: rtl/core/wvn_divider.sv
// ---------------------------------------------------------------------------
// wvn_divider
// Restoring divider, 32 quotient bits of floor(num * 2^31 / den), one per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module wvn_divider
  import wvn_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);
  logic              busy_q, busy_d, done_q, done_d;
  logic [4:0]        step_q, step_d;
  logic [RemW-1:0]   rem_q, rem_d, trial;
  logic [31:0]       quot_q, quot_d;
  logic [TotalW-1:0] den_q, den_d;
  logic              ge;

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    den_d  = den_q;
    done_d = 1'b0;
    trial  = (step_q == 5'd0) ? rem_q : {rem_q[RemW-2:0], 1'b0};
    ge     = trial >= {1'b0, den_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = RemW'(req_i.num);
      quot_d = '0;
      den_d  = req_i.den;
    end else if (busy_q) begin
      rem_d  = ge ? trial - {1'b0, den_q} : trial;
      quot_d = {quot_q[30:0], ge};
      step_d = step_q + 5'd1;
      if (step_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    den_q  <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
endmodule
`default_nettype wire

// File: rtl/core/weighted_vector_normalizer.sv
// ---------------------------------------------------------------------------
// weighted_vector_normalizer
// Normalizes a vector of weighted density samples to Q1.31 weights.
// ---------------------------------------------------------------------------
// Usage:
//   in_if carries one sample beat per cycle while the block is loading: a
//   signed Q8.24 value, its Q8.24 quadrature weight and a last mark. Samples
//   go into a 64-entry memory; the count and running maximum sit in flops.
//   After the last beat, in_if.ready stays low while the block evaluates.
//   Check and sum pass, per sample: memory read, multiply, add.
//   Emit pass, per sample: read, multiply, divider start, 32 divider
//   steps, load of the output register, then the beat is held until the
//   sink raises ready.
//   An error result from the count or maximum check comes from S_EVAL,
//   one from a weight or value check within the check pass. Errors give
//   one beat with norm_weight zero.
//   The output register holds its beat until out_if.ready; the block waits
//   and loading resumes after the beat marked last_out is taken.
//   Reset clears control state and sets grid_points to 64 and
//   tolerance_shift to 40; the memory needs no clearing.
//   Configuration writes are taken at any edge with cfg_we_i high.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module weighted_vector_normalizer
  import wvn_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  wvn_in_if.sink                   in_if,
  wvn_out_if.source                out_if,
  input  wire logic                cfg_we_i,
  input  wire cfg_reg_e            cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);
  state_e             state_q, state_d;
  logic [AddrW-1:0]   idx_q, idx_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               ovf_q, ovf_d;
  logic signed [31:0] max_q, max_d;
  logic [TotalW-1:0]  total_q, total_d;
  logic [ProdW-1:0]   prod_q, prod_d;
  logic               ovalid_q, ovalid_d, olast_q, olast_d;
  logic [31:0]        onorm_q, onorm_d;
  status_e            ostat_q, ostat_d;
  logic [GridW-1:0]   grid_q;
  logic [ShiftW-1:0]  tsh_q;

  logic               mem_we;
  logic [63:0]        rdata;
  logic signed [31:0] rval;
  logic [31:0]        rwt, tol;
  logic [30:0]        pos;
  logic signed [33:0] chk;
  logic [RemW-1:0]    sum;
  logic               at_end;
  logic               div_start;
  div_req_t           dreq;
  div_rsp_t           drsp;

  wvn_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (cnt_q[AddrW-1:0]),
    .wdata_i ({in_if.density_value, in_if.quad_weight}),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  wvn_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  assign rval     = $signed(rdata[63:32]);
  assign rwt      = rdata[31:0];
  assign pos      = (rval > 0) ? rval[30:0] : '0;
  assign tol      = 32'(max_q) >> tsh_q;
  assign chk      = 34'(rval) + $signed({2'b00, tol});
  assign sum      = {1'b0, total_q} + RemW'(prod_q[ProdW-1:16]);
  assign at_end   = (32'(idx_q) + 32'd1) == 32'(cnt_q);
  assign dreq     = '{start: div_start, num: prod_q[ProdW-1:16], den: total_q};

  assign in_if.ready        = (state_q == S_LOAD);
  assign out_if.valid       = ovalid_q;
  assign out_if.norm_weight = onorm_q;
  assign out_if.status      = ostat_q;
  assign out_if.last_out    = olast_q;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    max_d      = max_q;
    total_d    = total_q;
    prod_d     = prod_q;
    ovalid_d   = ovalid_q;
    onorm_d    = onorm_q;
    ostat_d    = ostat_q;
    olast_d    = olast_q;
    mem_we     = 1'b0;
    div_start  = 1'b0;
    unique case (state_q)
      S_LOAD: begin
        if (in_if.valid) begin
          if (32'(cnt_q) < MaxPoints) begin
            mem_we = 1'b1;
            cnt_d  = cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (in_if.density_value > max_q) begin
            max_d = in_if.density_value;
          end
          if (in_if.last_in) begin
            state_d = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        ovalid_d = 1'b1;
        onorm_d  = '0;
        olast_d  = 1'b1;
        state_d  = S_OUT;
        if (ovf_q || (32'(cnt_q) != 32'(grid_q))) begin
          ostat_d = ST_COUNT;
        end else if (max_q <= 0) begin
          ostat_d = ST_NO_POS;
        end else begin
          ovalid_d = 1'b0;
          idx_d    = '0;
          total_d  = '0;
          state_d  = S_CRD;
        end
      end
      S_CRD: state_d = S_CMUL;
      S_CMUL: begin
        prod_d  = ProdW'(pos) * ProdW'(rwt);
        state_d = S_CACC;
        if (rwt == '0) begin
          ovalid_d = 1'b1;
          onorm_d  = '0;
          ostat_d  = ST_BAD_WT;
          olast_d  = 1'b1;
          state_d  = S_OUT;
        end else if (chk < 0) begin
          ovalid_d = 1'b1;
          onorm_d  = '0;
          ostat_d  = ST_TOO_NEG;
          olast_d  = 1'b1;
          state_d  = S_OUT;
        end
      end
      S_CACC: begin
        total_d = sum[RemW-1] ? TotalMax : sum[TotalW-1:0];
        if (at_end) begin
          idx_d = '0;
          if (sum == '0) begin
            ovalid_d = 1'b1;
            onorm_d  = '0;
            ostat_d  = ST_ZERO_SUM;
            olast_d  = 1'b1;
            state_d  = S_OUT;
          end else begin
            state_d = S_DRD;
          end
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_CRD;
        end
      end
      S_DRD: state_d = S_DMUL;
      S_DMUL: begin
        prod_d  = ProdW'(pos) * ProdW'(rwt);
        state_d = S_DST;
      end
      S_DST: begin
        div_start = 1'b1;
        state_d   = S_DDIV;
      end
      S_DDIV: begin
        if (drsp.done) begin
          ovalid_d = 1'b1;
          onorm_d  = drsp.quot;
          ostat_d  = ST_OK;
          olast_d  = at_end;
          state_d  = S_OUT;
        end
      end
      S_OUT: begin
        if (out_if.ready) begin
          ovalid_d = 1'b0;
          if (olast_q) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            max_d   = '0;
            total_d = '0;
            idx_d   = '0;
            state_d = S_LOAD;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_DRD;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_LOAD;
      idx_q    <= '0;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      max_q    <= '0;
      total_q  <= '0;
      ovalid_q <= 1'b0;
      olast_q  <= 1'b0;
      ostat_q  <= ST_OK;
      grid_q   <= GridW'(MaxPoints);
      tsh_q    <= ShiftW'(40);
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      cnt_q    <= cnt_d;
      ovf_q    <= ovf_d;
      max_q    <= max_d;
      total_q  <= total_d;
      ovalid_q <= ovalid_d;
      olast_q  <= olast_d;
      ostat_q  <= ostat_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_GRID_POINTS: grid_q <= cfg_data_i[GridW-1:0];
          CFG_TOL_SHIFT:   tsh_q  <= cfg_data_i[ShiftW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    onorm_q <= onorm_d;
  end

  `WVN_ASSERT(a_ready_no_out, !(in_if.ready && out_if.valid), "input taken while result pending")
  `WVN_ASSERT(a_err_last, (!out_if.valid || out_if.status == ST_OK || out_if.last_out), "error beat not marked last")
  `WVN_ASSERT(a_cnt_range, (32'(cnt_q) <= MaxPoints), "sample count beyond memory depth")
  `WVN_ASSERT_NEXT(a_last_clears, out_if.valid && out_if.ready && out_if.last_out, cnt_q == '0 && in_if.ready, "run not cleared after last beat")
endmodule
`default_nettype wire

// File: tb/weighted_vector_normalizer_test.sv
// ---------------------------------------------------------------------------
// weighted_vector_normalizer_test
// Drives sample vectors through the normalizer under random bursts and sink
// stalls, predicts every result beat and compares weight, status and last mark.
// ---------------------------------------------------------------------------
module weighted_vector_normalizer_test
  import wvn_pkg::*;
();

  typedef struct packed {
    logic [31:0] norm_weight;
    logic [2:0]  status;
    logic        last_out;
  } result_t;

  class norm_board;
    logic [31:0] vals[MaxPoints];
    logic [31:0] wts[MaxPoints];
    int unsigned cnt;
    bit          ovf;
    longint      peak;
    int unsigned grid = 64;
    int unsigned shift = 40;
    result_t     pending[$];
    int          mismatches;

    function void clear_vec();
      cnt = 0; ovf = 0; peak = 0;
    endfunction

    function logic [63:0] prod(int i);
      longint v;
      logic [63:0] p;
      v = longint'($signed(vals[i]));
      p = (v > 0) ? 64'(v) : 64'd0;
      return (p * 64'(wts[i])) >> 16;
    endfunction

    function void push_err(status_e code);
      result_t r;
      r.norm_weight = 0; r.status = code; r.last_out = 1'b1;
      pending.push_back(r);
      clear_vec();
    endfunction

    function void note_sample(logic [31:0] v, logic [31:0] w, logic last);
      longint tol, sv;
      logic [63:0] total, num;
      logic [127:0] q;
      result_t r;
      sv = longint'($signed(v));
      if (cnt < MaxPoints) begin
        vals[cnt] = v; wts[cnt] = w; cnt++;
      end else ovf = 1;
      if (sv > peak) peak = sv;
      if (!last) return;
      if (ovf || cnt != grid) begin push_err(ST_COUNT); return; end
      if (peak <= 0) begin push_err(ST_NO_POS); return; end
      tol = longint'(64'(peak) >> shift);
      total = 0;
      for (int i = 0; i < cnt; i++) begin
        if (wts[i] == 0) begin push_err(ST_BAD_WT); return; end
        if (longint'($signed(vals[i])) < -tol) begin push_err(ST_TOO_NEG); return; end
        total += prod(i);
        if (total > 64'(TotalMax)) total = 64'(TotalMax);
      end
      if (total == 0) begin push_err(ST_ZERO_SUM); return; end
      for (int i = 0; i < cnt; i++) begin
        num = prod(i);
        q = ({64'd0, num} << 31) / {64'd0, total};
        r.norm_weight = q[31:0]; r.status = ST_OK; r.last_out = (i + 1 == cnt);
        pending.push_back(r);
      end
      clear_vec();
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp w=%h s=%0d l=%b got w=%h s=%0d l=%b",
                   exp.norm_weight, exp.status, exp.last_out,
                   got.norm_weight, got.status, got.last_out);
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic cfg_we_i = 0;
  cfg_reg_e cfg_idx_i = CFG_GRID_POINTS;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  wvn_in_if  in_if();
  wvn_out_if out_if();
  norm_board board = new();
  int idle_cycles, sent;
  bit stall_mode;

  weighted_vector_normalizer u_top (.clk_i, .rst_ni, .in_if(in_if.sink),
    .out_if(out_if.source), .cfg_we_i, .cfg_idx_i, .cfg_data_i);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    in_if.valid = 0; in_if.density_value = 0; in_if.quad_weight = 0; in_if.last_in = 0;
    out_if.ready = 0;
  end

  always @(posedge clk_i) begin
    if (in_if.valid && in_if.ready)
      board.note_sample(in_if.density_value, in_if.quad_weight, in_if.last_in);
    if (out_if.valid && out_if.ready)
      board.check_result({out_if.norm_weight, out_if.status, out_if.last_out});
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > 20000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
    out_if.ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  task automatic write_reg(cfg_reg_e idx, int unsigned data);
    @(posedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= CfgDataW'(data);
    @(posedge clk_i);
    cfg_we_i <= 0;
    if (idx == CFG_GRID_POINTS) board.grid = data; else board.shift = data;
  endtask

  // valid stays high after a beat until the next beat or a gap replaces it
  task automatic send_beat(logic [31:0] v, logic [31:0] w, logic last);
    if ($urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 6)) begin
        in_if.valid <= 0;
        @(posedge clk_i);
      end
    in_if.valid <= 1; in_if.density_value <= v; in_if.quad_weight <= w;
    in_if.last_in <= last;
    do @(posedge clk_i); while (!in_if.ready);
    sent++;
  endtask

  function automatic logic [31:0] rand_val(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(1, 32'h7fffffff);
      default: return -$urandom_range(0, 4);
    endcase
  endfunction

  task automatic send_vec(int n, int mode);
    logic [31:0] v, w;
    for (int i = 0; i < n; i++) begin
      v = (mode == 3) ? rand_val(0) : rand_val($urandom_range(1, 2));
      w = $urandom();
      if (mode != 3 && w == 0) w = 1;
      if (mode == 2 && $urandom_range(0, 7) == 0) w = 0;
      send_beat(v, w, i == n - 1);
    end
  endtask

  task automatic settle();
    in_if.valid <= 0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  initial begin
    int n;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    write_reg(CFG_GRID_POINTS, 2);
    write_reg(CFG_TOL_SHIFT, 0);
    send_beat(32'h7fffffff, 32'hffffffff, 0); send_beat(32'h80000000, 32'h1, 1);
    send_beat(32'h01000000, 32'h01000000, 0); send_beat(-32'sd1, 32'h1, 1);
    send_beat(32'h0, 32'h1, 0); send_beat(32'h0, 32'h1, 1);
    send_beat(32'h1, 32'h0, 0); send_beat(32'h1, 32'h1, 1);
    send_beat(32'h1, 32'h1, 0); send_beat(32'h1, 32'h1, 1);
    send_beat(32'h5, 32'h1, 1);
    send_beat(32'h7fffffff, 32'h7, 0); send_beat(32'h7fffffff, 32'h7, 1);
    settle();
    write_reg(CFG_TOL_SHIFT, 63);
    send_beat(32'h1, 32'h1, 0); send_beat(-32'sd1, 32'h1, 1);
    send_beat(32'h1, 32'h1, 0); send_beat(32'h1, 32'h1, 0); send_beat(32'h1, 32'h1, 1);
    settle();
    write_reg(CFG_GRID_POINTS, 64);
    send_vec(64, 1);
    settle();
    while (sent < 110) begin
      n = $urandom_range(2, 8);
      write_reg(CFG_GRID_POINTS, n);
      write_reg(CFG_TOL_SHIFT, $urandom_range(0, 63));
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 9))
          0: send_vec(n + $urandom_range(0, 1) * 2 - 1, 1);
          1: send_vec(n, 2);
          2: send_vec(n, 3);
          default: send_vec(n, 1);
        endcase
      end
      settle();
    end
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// File: weighted_vector_normalizer.f
+incdir+rtl/core
rtl/core/wvn_pkg.sv
rtl/core/wvn_if.sv
rtl/core/wvn_store.sv
rtl/core/wvn_divider.sv
rtl/core/weighted_vector_normalizer.sv
tb/weighted_vector_normalizer_test.sv
